// File: hdl/mpdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mate-pair dedup insert package
// Shared widths, default sizes, status codes, FSM states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mpdi_pkg;

  // Default sizes of the table and the stored identifier
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 40;

  // Field widths of the stream payloads
  localparam int MATE_ID_W = 40;
  localparam int ORIENT_W  = 2;
  localparam int DATASET_W = 8;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;

  // Packed stream widths, padded to whole bytes
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 16;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_APPENDED = 2'd0,
    STATUS_PRESENT  = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the offered record and restart the scan
    logic scan;    // step the table scan by one slot
    logic commit;  // publish the result and append if needed
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;        // the entry read last cycle matches the record
    logic exhausted;  // every stored entry has been compared
    logic out_free;   // the output register can take a result
  } ctrl_sts_t;

endpackage

// File: hdl/mate_pair_dedup_insert_top.sv
`timescale 1ns / 1ps
// Sequence: accept the record, scan the stored entries in slot order (ending early
// on a match), then publish the result into the output register once it is free.
// Throughput: one record in flight; a new record is accepted only once the
// last result is published. The scan reads the table RAM one entry per cycle.
// Reset: asynchronous, active low; empties the table (count zero) and drops
// any pending result. Table contents are not cleared.
// ----------------------------------------------------------------------------
// Mate-pair dedup insert top level
// Appends distinct {id, orientation, dataset} records to a fixed-depth table
// and reports appended, already present or table full.
// ----------------------------------------------------------------------------
module mate_pair_dedup_insert_top #(
  parameter int TABLE_DEPTH = mpdi_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = mpdi_pkg::ID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [39:0] mate_id, [41:40] mate_orientation, [49:42] dataset_index
  input  logic [mpdi_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [5:2] entry_slot, [10:6] entry_count
  output logic [mpdi_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import mpdi_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  mpdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, compare and result path
  mpdi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  // One record in flight: no new transfer right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a record is in progress");

  // Commands are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("controller issued overlapping commands");

  // A result is published only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result overwrote a pending output");

  // A refused record reports a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[STATUS_W-1:0] == STATUS_FULL)) |->
      (m_axis_tdata_o[STATUS_W+SLOT_W+COUNT_W-1:STATUS_W+SLOT_W] ==
       COUNT_W'(TABLE_DEPTH)))
    else $error("full status with a table that is not full");

endmodule

// File: hdl/mpdi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mpdi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mate-pair dedup insert controller
// Sequences one record at a time: accept, scan the table, publish the result.
// ----------------------------------------------------------------------------
module mpdi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  mpdi_pkg::ctrl_sts_t sts_i,
  output mpdi_pkg::ctrl_cmd_t cmd_o
);

  import mpdi_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.exhausted) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/mpdi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mate-pair dedup insert datapath
// Holds the offered record, the entry count, the scan pointer, the table RAM
// and the output register.
// ----------------------------------------------------------------------------
module mpdi_datapath #(
  parameter int TABLE_DEPTH = mpdi_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = mpdi_pkg::ID_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mpdi_pkg::S_TDATA_W-1:0]  s_tdata_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [mpdi_pkg::M_TDATA_W-1:0]  m_tdata_o,
  input  mpdi_pkg::ctrl_cmd_t             cmd_i,
  output mpdi_pkg::ctrl_sts_t             sts_o
);

  import mpdi_pkg::*;

  localparam int KW  = (ID_BITS < MATE_ID_W) ? ID_BITS : MATE_ID_W;
  localparam int RW  = KW + ORIENT_W + DATASET_W;
  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int PAD = M_TDATA_W - STATUS_W - SLOT_W - COUNT_W;

  logic [RW-1:0] rec_q, rec_in;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_idx_q;
  logic          cmp_valid_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q;
  logic [IW-1:0] found_slot_q;
  logic          rd_en;
  logic [RW-1:0] rd_data;
  logic          more;
  logic          full;
  logic          append;
  status_e       status;
  logic [IW-1:0] slot;
  logic [IW+SLOT_W-1:0]  slot_wide;
  logic [CW+COUNT_W-1:0] count_wide;
  logic                  out_valid_q;
  logic [M_TDATA_W-1:0]  out_data_q;

  // Unpack the offered record, keeping the low identifier bits
  assign rec_in = {s_tdata_i[MATE_ID_W+ORIENT_W+DATASET_W-1:MATE_ID_W+ORIENT_W],
                   s_tdata_i[MATE_ID_W+ORIENT_W-1:MATE_ID_W],
                   s_tdata_i[KW-1:0]};

  // Scan: read one stored entry per cycle, compare it the cycle after
  assign more  = (scan_idx_q < count_q);
  assign rd_en = cmd_i.scan && more;

  // Finish the scan as soon as the last entry has been compared without a hit
  assign sts_o.hit       = cmp_valid_q && (rd_data == rec_q);
  assign sts_o.exhausted = !more && !sts_o.hit;
  assign sts_o.out_free  = !out_valid_q || m_tready_i;

  // Resolve the result
  assign full   = (count_q == CW'(TABLE_DEPTH));
  assign append = cmd_i.commit && !found_q && !full;
  assign count_d = append ? count_q + CW'(1) : count_q;

  always_comb begin
    if (found_q) begin
      status = STATUS_PRESENT;
      slot   = found_slot_q;
    end else if (full) begin
      status = STATUS_FULL;
      slot   = '0;
    end else begin
      status = STATUS_APPENDED;
      slot   = count_q[IW-1:0];
    end
  end

  // Mask slot and count to the result field widths
  assign slot_wide  = {{SLOT_W{1'b0}}, slot};
  assign count_wide = {{COUNT_W{1'b0}}, count_d};

  // Table storage
  mpdi_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (append),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (rec_q),
    .re_i    (rd_en),
    .raddr_i (scan_idx_q[IW-1:0]),
    .rdata_o (rd_data)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cmp_valid_q <= rd_en;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Record, scan pointer and match capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rec_q      <= rec_in;
      scan_idx_q <= '0;
      found_q    <= 1'b0;
    end else begin
      if (rd_en) begin
        scan_idx_q <= scan_idx_q + CW'(1);
      end
      if (cmd_i.scan && sts_o.hit) begin
        found_q      <= 1'b1;
        found_slot_q <= cmp_idx_q;
      end
    end
    if (rd_en) begin
      cmp_idx_q <= scan_idx_q[IW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {{PAD{1'b0}}, count_wide[COUNT_W-1:0],
                     slot_wide[SLOT_W-1:0], status};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

// File: sim/tb_mate_pair_dedup_insert_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mate-pair dedup insert testbench
// Streams mate-pair records into the table and checks each result transfer
// against a scoreboard that keeps its own copy of the table. Stimulus covers
// field extremes, exact repeats, near misses in each field and the full
// table. Both stream sides idle at random, and the output side holds off once
// for a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------

// One offered record, in the field order of the input stream
typedef struct packed {
  logic [mpdi_pkg::DATASET_W-1:0] dataset;
  logic [mpdi_pkg::ORIENT_W-1:0]  orient;
  logic [mpdi_pkg::MATE_ID_W-1:0] id;
} mate_rec_t;

// One awaited result
typedef struct {
  mpdi_pkg::status_e               status;
  logic [mpdi_pkg::SLOT_W-1:0]     slot;
  logic [mpdi_pkg::COUNT_W-1:0]    count;
} insert_outcome_t;

// Track the table contents and the results they imply
class dedup_scoreboard;
  localparam int DEPTH = mpdi_pkg::TABLE_DEPTH_DEF;
  // Only the low ID_BITS of the identifier take part in the compare
  localparam logic [mpdi_pkg::MATE_ID_W-1:0] ID_KEEP =
    (mpdi_pkg::ID_BITS_DEF >= mpdi_pkg::MATE_ID_W) ? '1 :
    ((40'd1 << mpdi_pkg::ID_BITS_DEF) - 40'd1);

  mate_rec_t       stored[DEPTH];
  int unsigned     n_stored;
  insert_outcome_t awaited[$];
  int unsigned     fails;

  function new();
    n_stored = 0;
    fails    = 0;
  endfunction

  // Look up the record in slot order, append it if new and room is left
  function void note_record(mate_rec_t rec);
    insert_outcome_t o;
    bit              found;
    rec.id   = rec.id & ID_KEEP;
    o.status = mpdi_pkg::STATUS_FULL;
    o.slot   = '0;
    found    = 1'b0;
    for (int unsigned i = 0; i < n_stored; i++) begin
      if (!found && stored[i] == rec) begin
        found    = 1'b1;
        o.slot   = i[mpdi_pkg::SLOT_W-1:0];
        o.status = mpdi_pkg::STATUS_PRESENT;
      end
    end
    if (!found && n_stored < DEPTH) begin
      o.slot           = n_stored[mpdi_pkg::SLOT_W-1:0];
      stored[n_stored] = rec;
      n_stored++;
      o.status         = mpdi_pkg::STATUS_APPENDED;
    end
    o.count = n_stored[mpdi_pkg::COUNT_W-1:0];
    awaited.insert(awaited.size(), o);
  endfunction

  // Compare one result transfer with the oldest awaited outcome
  function void check_result(logic [mpdi_pkg::M_TDATA_W-1:0] tdata);
    insert_outcome_t            o;
    logic [mpdi_pkg::STATUS_W-1:0] got_status;
    logic [mpdi_pkg::SLOT_W-1:0]   got_slot;
    logic [mpdi_pkg::COUNT_W-1:0]  got_count;
    {got_count, got_slot, got_status} =
      tdata[mpdi_pkg::COUNT_W+mpdi_pkg::SLOT_W+mpdi_pkg::STATUS_W-1:0];
    if (awaited.size() == 0) begin
      $error("result with nothing awaited: tdata %h", tdata);
      fails++;
      return;
    end
    o = awaited.pop_front();
    if (got_status !== o.status) begin
      $error("status: expected %0d, actual %0d", o.status, got_status);
      fails++;
    end
    if (got_slot !== o.slot) begin
      $error("entry_slot: expected %0d, actual %0d", o.slot, got_slot);
      fails++;
    end
    if (got_count !== o.count) begin
      $error("entry_count: expected %0d, actual %0d", o.count, got_count);
      fails++;
    end
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction
endclass

module tb_mate_pair_dedup_insert_top;

  localparam int RANDOM_ITEMS = 625;
  localparam int HOLD_AT_ITEM = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 499;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [mpdi_pkg::S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [mpdi_pkg::M_TDATA_W-1:0] m_axis_tdata_o;

  dedup_scoreboard sb = new();
  mate_rec_t       offered[$];
  int unsigned     n_sent    = 0;
  int unsigned     cycles    = 0;
  bit              calm      = 1'b0;
  bit              hold_req  = 1'b0;

  mate_pair_dedup_insert_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Toggle the clock
  always #1 clk_i = ~clk_i;

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
  end

  // Drive the output ready: random idling, one long hold-off
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        m_axis_tready_i <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // Offer one record and wait for its input transfer
  task automatic offer_record(mate_rec_t rec);
    logic [63:0] noise;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 27) begin
      noise           = {$urandom(), $urandom()};
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= noise[mpdi_pkg::S_TDATA_W-1:0];
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(mpdi_pkg::S_TDATA_W - $bits(mate_rec_t)){1'b0}}, rec};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_record(rec);
    offered.insert(offered.size(), rec);
    n_sent++;
    calm     = (n_sent >= CALM_FIRST) && (n_sent <= CALM_LAST);
    hold_req = hold_req || (n_sent >= HOLD_AT_ITEM);
  endtask

  function automatic mate_rec_t fresh_record();
    mate_rec_t   rec;
    logic [63:0] w;
    w           = {$urandom(), $urandom()};
    rec.id      = w[mpdi_pkg::MATE_ID_W-1:0];
    rec.orient  = w[mpdi_pkg::MATE_ID_W +: mpdi_pkg::ORIENT_W];
    rec.dataset = w[mpdi_pkg::MATE_ID_W+mpdi_pkg::ORIENT_W +: mpdi_pkg::DATASET_W];
    return rec;
  endfunction

  function automatic mate_rec_t make_record(logic [39:0] id, logic [1:0] orient,
                                            logic [7:0] dataset);
    mate_rec_t rec;
    rec.id      = id;
    rec.orient  = orient;
    rec.dataset = dataset;
    return rec;
  endfunction

  // Flip one bit of one field of a record
  function automatic mate_rec_t near_miss(mate_rec_t rec);
    int unsigned b;
    case ($urandom_range(0, 2))
      0: begin
        b = $urandom_range(0, mpdi_pkg::MATE_ID_W - 1);
        rec.id[b] = ~rec.id[b];
      end
      1: begin
        b = $urandom_range(0, mpdi_pkg::ORIENT_W - 1);
        rec.orient[b] = ~rec.orient[b];
      end
      default: begin
        b = $urandom_range(0, mpdi_pkg::DATASET_W - 1);
        rec.dataset[b] = ~rec.dataset[b];
      end
    endcase
    return rec;
  endfunction

  // Main sequence
  initial begin
    mate_rec_t rec;
    int unsigned pick;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, repeats and single-field near misses
    offer_record(make_record('0, 2'd0, 8'd0));
    offer_record(make_record('1, 2'd3, 8'd255));
    offer_record(make_record('0, 2'd0, 8'd0));
    offer_record(make_record('0, 2'd1, 8'd0));
    offer_record(make_record('0, 2'd2, 8'd0));
    offer_record(make_record('0, 2'd0, 8'd1));
    offer_record(make_record('0, 2'd0, 8'd128));
    offer_record(make_record(40'd1, 2'd0, 8'd0));
    offer_record(make_record(40'h80_0000_0000, 2'd0, 8'd0));
    offer_record(make_record('1, 2'd3, 8'd255));

    // Fill the table to the last slot
    while (sb.n_stored < mpdi_pkg::TABLE_DEPTH_DEF) begin
      offer_record(fresh_record());
    end

    // Duplicate while full, then new records while full
    offer_record(sb.stored[mpdi_pkg::TABLE_DEPTH_DEF-1]);
    offer_record(sb.stored[0]);
    offer_record(make_record(40'h55_5555_5555, 2'd1, 8'd170));
    offer_record(near_miss(sb.stored[mpdi_pkg::TABLE_DEPTH_DEF-1]));

    // Random mix of repeats, near misses and fresh records
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        rec = offered[$urandom_range(0, offered.size() - 1)];
      end else if (pick < 75) begin
        rec = near_miss(offered[$urandom_range(0, offered.size() - 1)]);
      end else begin
        rec = fresh_record();
      end
      offer_record(rec);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // Drain, then let a late extra result show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
